/* rtl/tccu_pkg.sv */
// Shared types and constants of the timestamp clock compensator.
// No dependencies; every other file of the block uses this package.
package tccu_pkg;

    localparam logic [63:0] TICKS_PER_SECOND = 64'd63897600000;
    localparam int          TIMESTAMP_BITS   = 40;

    localparam int TIME_W  = 64;
    localparam int SHORT_W = 40;
    localparam int SKEW_W  = 34;
    localparam int COEF_W  = 64;
    localparam int PROD_W  = 128;
    localparam int CFG_IDX_W = 3;

    localparam logic [SKEW_W-1:0] SKEW_RESET = 34'h1_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL_VALID       = 3'd0,
        CFG_SKEW_FACTOR       = 3'd1,
        CFG_LOCAL_EPOCH_LOW   = 3'd2,
        CFG_MASTER_EPOCH_FULL = 3'd3,
        CFG_MASTER_EPOCH_LOW  = 3'd4,
        CFG_OFFSET_COEFF      = 3'd5,
        CFG_RATE_COEFF        = 3'd6,
        CFG_DRIFT_COEFF       = 3'd7
    } t_cfg_idx;

    // load enables of the three register levels of a pipelined multiplier
    typedef struct packed {
        logic ld_part;
        logic ld_mid;
        logic ld_out;
    } t_mul_en;

endpackage

/* rtl/tccu_in_if.sv */
// Input item channel of the timestamp clock compensator.
// Depends on tccu_pkg for the field width.
interface tccu_in_if;
    logic                        valid;
    logic                        ready;
    logic [tccu_pkg::TIME_W-1:0] local_time;

    modport source (output valid, output local_time, input ready);
    modport sink   (input valid, input local_time, output ready);
endinterface

/* rtl/tccu_out_if.sv */
// Result item channel of the timestamp clock compensator.
// Depends on tccu_pkg for the field widths.
interface tccu_out_if;
    logic                         valid;
    logic                         ready;
    logic [tccu_pkg::SHORT_W-1:0] skew_adjusted_time;
    logic [tccu_pkg::TIME_W-1:0]  master_time_wide;
    logic [tccu_pkg::SHORT_W-1:0] master_time_narrow;

    modport source (output valid, output skew_adjusted_time, output master_time_wide,
                    output master_time_narrow, input ready);
    modport sink   (input valid, input skew_adjusted_time, input master_time_wide,
                    input master_time_narrow, output ready);
endinterface

/* rtl/tccu_mul.sv */
// Three-level pipelined 64x64 unsigned multiplier built from 32x32 partials.
// Depends on tccu_pkg (t_mul_en, widths).
module tccu_mul (
    input  logic                          i_clk,
    input  tccu_pkg::t_mul_en             i_en,
    input  logic [tccu_pkg::TIME_W-1:0]   i_a,
    input  logic [tccu_pkg::TIME_W-1:0]   i_b,
    output logic [tccu_pkg::PROD_W-1:0]   o_p
);
    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    logic [64:0]  r_mid;
    logic [63:0]  r_ll2;
    logic [63:0]  r_hh2;
    logic [127:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en.ld_part) begin
            r_ll <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
            r_lh <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
            r_hl <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
            r_hh <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
        end
        if (i_en.ld_mid) begin
            r_mid <= 65'(r_lh) + 65'(r_hl);
            r_ll2 <= r_ll;
            r_hh2 <= r_hh;
        end
        if (i_en.ld_out) begin
            r_p <= {r_hh2, r_ll2} + (128'(r_mid) << 32);
        end
    end

    assign o_p = r_p;

endmodule

/* rtl/timestamp_clock_compensator_unit.sv */
// Top level of the timestamp clock compensator: config registers and pipeline.
// Depends on tccu_pkg, tccu_in_if, tccu_out_if and tccu_mul.
//
// Takes one local timestamp per cycle while the output is not stalled and
// returns one item with the skew-corrected time and the time projected into
// the master frame, throughput one item per clock. The depth follows from
// three dependent 64x64 products (interval from delta and the tick
// reciprocal, interval squared, drift times half the square), each a
// three-level multiplier. Each stage advances when it is empty or its
// successor moves, so bubbles close up; input can be taken while a finished
// item waits at the output if an earlier stage is empty. Configuration
// writes are single-cycle and are expected only while the pipeline is empty.
module timestamp_clock_compensator_unit #(
    parameter logic [63:0] TICKS_PER_SECOND = tccu_pkg::TICKS_PER_SECOND,
    parameter int          TIMESTAMP_BITS   = tccu_pkg::TIMESTAMP_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tccu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tccu_pkg::COEF_W-1:0]      i_cfg_data,
    tccu_in_if.sink                          i_in,
    tccu_out_if.source                       o_out
);
    localparam int          TB            = TIMESTAMP_BITS;
    localparam logic [63:0] RECIP         = 64'hFFFF_FFFF_FFFF_FFFF / TICKS_PER_SECOND;
    localparam logic [63:0] EPOCH_HI_MASK = ~((64'd1 << TB) - 64'd1);
    localparam int          NS            = 15;

    // configuration registers
    logic                              r_model_valid;
    logic [tccu_pkg::SKEW_W-1:0]       r_skew_factor;
    logic [tccu_pkg::SHORT_W-1:0]      r_local_epoch_low;
    logic [tccu_pkg::TIME_W-1:0]       r_master_epoch_full;
    logic [tccu_pkg::SHORT_W-1:0]      r_master_epoch_low;
    logic [tccu_pkg::COEF_W-1:0]       r_offset_coeff;
    logic [tccu_pkg::COEF_W-1:0]       r_rate_coeff;
    logic [tccu_pkg::COEF_W-1:0]       r_drift_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_valid       <= 1'b0;
            r_skew_factor       <= tccu_pkg::SKEW_RESET;
            r_local_epoch_low   <= '0;
            r_master_epoch_full <= '0;
            r_master_epoch_low  <= '0;
            r_offset_coeff      <= '0;
            r_rate_coeff        <= '0;
            r_drift_coeff       <= '0;
        end else if (i_cfg_we) begin
            case (tccu_pkg::t_cfg_idx'(i_cfg_idx))
                tccu_pkg::CFG_MODEL_VALID:       r_model_valid       <= i_cfg_data[0];
                tccu_pkg::CFG_SKEW_FACTOR:       r_skew_factor       <= i_cfg_data[33:0];
                tccu_pkg::CFG_LOCAL_EPOCH_LOW:   r_local_epoch_low   <= i_cfg_data[39:0];
                tccu_pkg::CFG_MASTER_EPOCH_FULL: r_master_epoch_full <= i_cfg_data;
                tccu_pkg::CFG_MASTER_EPOCH_LOW:  r_master_epoch_low  <= i_cfg_data[39:0];
                tccu_pkg::CFG_OFFSET_COEFF:      r_offset_coeff      <= i_cfg_data;
                tccu_pkg::CFG_RATE_COEFF:        r_rate_coeff        <= i_cfg_data;
                tccu_pkg::CFG_DRIFT_COEFF:       r_drift_coeff       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage control
    logic [NS:1]   r_v;
    logic [NS+1:1] w_en;

    always_comb begin
        w_en[NS+1] = o_out.ready;
        for (int k = NS; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= i_in.valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // datapath
    logic [63:0]   r_t1;
    logic [TB-1:0] r_dl1;
    logic [TB-1:0] n_dl1;
    logic [63:0]   r_nvlo [2:NS-1];
    logic [39:0]   r_adj  [2:NS];
    logic [63:0]   r_tq   [5:8];
    logic [63:0]   r_h    [9:12];
    logic [63:0]   r_rs   [9:12];
    logic [63:0]   r_p13;
    logic [63:0]   r_lo14;
    logic [63:0]   r_wide15;

    logic [127:0]  w_pa;
    logic [127:0]  w_pb;
    logic [127:0]  w_pc;
    logic [127:0]  w_pd;
    logic [127:0]  w_pe;

    logic [63:0]   n_tq5;
    logic [63:0]   n_h9;
    logic [63:0]   n_rs9;
    logic [63:0]   n_p13;
    logic [63:0]   n_lo14;

    assign n_dl1 = i_in.local_time[TB-1:0] - TB'(r_local_epoch_low);

    always_comb begin
        n_tq5  = (w_pb[127:88] != '0) ? '1 : w_pb[87:24];
        n_h9   = (w_pc[127:105] != '0) ? '1 : w_pc[104:41];
        n_rs9  = w_pd[111:48] - (r_rate_coeff[63] ? {r_tq[8][47:0], 16'h0000} : 64'd0);
        n_p13  = r_rs[12] + w_pe[111:48]
               - (r_drift_coeff[63] ? {r_h[12][47:0], 16'h0000} : 64'd0);
        // truncate toward zero: round negative values up
        n_lo14 = r_p13[63] ? 64'($signed(r_p13 + 64'd65535) >>> 16)
                           : 64'($signed(r_p13) >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_t1  <= i_in.local_time;
            r_dl1 <= n_dl1;
        end
        if (w_en[2]) begin
            r_nvlo[2] <= 64'(r_master_epoch_low) + 64'(r_dl1);
            r_adj[2]  <= r_t1[39:0];
        end
        for (int k = 3; k <= NS-1; k++) begin
            if (w_en[k]) begin
                r_nvlo[k] <= r_nvlo[k-1];
            end
        end
        if (w_en[3]) begin
            r_adj[3] <= r_adj[2];
        end
        if (w_en[4]) begin
            r_adj[4] <= r_adj[3];
        end
        if (w_en[5]) begin
            r_adj[5] <= r_model_valid ? w_pa[71:32] : r_adj[4];
        end
        for (int k = 6; k <= NS; k++) begin
            if (w_en[k]) begin
                r_adj[k] <= r_adj[k-1];
            end
        end
        if (w_en[5]) begin
            r_tq[5] <= n_tq5;
        end
        for (int k = 6; k <= 8; k++) begin
            if (w_en[k]) begin
                r_tq[k] <= r_tq[k-1];
            end
        end
        if (w_en[9]) begin
            r_h[9]  <= n_h9;
            r_rs[9] <= n_rs9;
        end
        if (w_en[10]) begin
            r_h[10]  <= r_h[9];
            r_rs[10] <= r_offset_coeff + r_rs[9];
        end
        for (int k = 11; k <= 12; k++) begin
            if (w_en[k]) begin
                r_h[k]  <= r_h[k-1];
                r_rs[k] <= r_rs[k-1];
            end
        end
        if (w_en[13]) begin
            r_p13 <= n_p13;
        end
        if (w_en[14]) begin
            r_lo14 <= n_lo14;
        end
        if (w_en[15]) begin
            r_wide15 <= (r_master_epoch_full & EPOCH_HI_MASK)
                      + (r_model_valid ? r_lo14 : r_nvlo[14]);
        end
    end

    // multipliers
    tccu_mul u_mul_skew (
        .i_clk (i_clk),
        .i_en  ('{ld_part: w_en[2], ld_mid: w_en[3], ld_out: w_en[4]}),
        .i_a   (r_t1),
        .i_b   (64'(r_skew_factor)),
        .o_p   (w_pa)
    );

    tccu_mul u_mul_intv (
        .i_clk (i_clk),
        .i_en  ('{ld_part: w_en[2], ld_mid: w_en[3], ld_out: w_en[4]}),
        .i_a   (64'(r_dl1)),
        .i_b   (RECIP),
        .o_p   (w_pb)
    );

    tccu_mul u_mul_sq (
        .i_clk (i_clk),
        .i_en  ('{ld_part: w_en[6], ld_mid: w_en[7], ld_out: w_en[8]}),
        .i_a   (r_tq[5]),
        .i_b   (r_tq[5]),
        .o_p   (w_pc)
    );

    tccu_mul u_mul_rate (
        .i_clk (i_clk),
        .i_en  ('{ld_part: w_en[6], ld_mid: w_en[7], ld_out: w_en[8]}),
        .i_a   (r_rate_coeff),
        .i_b   (r_tq[5]),
        .o_p   (w_pd)
    );

    tccu_mul u_mul_drift (
        .i_clk (i_clk),
        .i_en  ('{ld_part: w_en[10], ld_mid: w_en[11], ld_out: w_en[12]}),
        .i_a   (r_drift_coeff),
        .i_b   (r_h[9]),
        .o_p   (w_pe)
    );

    assign i_in.ready               = w_en[1];
    assign o_out.valid              = r_v[NS];
    assign o_out.skew_adjusted_time = r_adj[NS];
    assign o_out.master_time_wide   = r_wide15;
    assign o_out.master_time_narrow = r_wide15[39:0];

`ifndef SYNTHESIS
    a_empty_out_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NS] |-> i_in.ready)
        else $error("input not ready with an empty output stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v[1])
        else $error("accepted item missing from first stage");

    a_blocked_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[14] && !w_en[14]) |=> (r_v[14] && $stable(r_lo14)))
        else $error("blocked stage lost or changed its item");

    a_reset_empties: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_v == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule
